// ===== sv/ldpm_pkg.sv =====
// shared types, constants and helpers of the lens distortion point map unit
// no dependencies; the top level, front end, queue and back end refer to this package
package ldpm_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QAddrW  = $clog2(QDepth);

  localparam logic signed [31:0] RADIAL_K3_DEFAULT = 32'sd0;
  localparam logic signed [31:0] FOCAL_RESET       = 32'sd256000;
  localparam logic signed [63:0] Q24_ONE           = 64'sd16777216;
  localparam logic signed [63:0] S32_MAX           = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN           = -64'sd2147483648;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_PRINCIPAL_X   = 3'd0,
    REG_PRINCIPAL_Y   = 3'd1,
    REG_FOCAL_X       = 3'd2,
    REG_FOCAL_Y       = 3'd3,
    REG_RADIAL_K1     = 3'd4,
    REG_RADIAL_K2     = 3'd5,
    REG_TANGENTIAL_P1 = 3'd6,
    REG_TANGENTIAL_P2 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] principal_x;
    logic signed [31:0] principal_y;
    logic signed [31:0] focal_x;
    logic signed [31:0] focal_y;
    logic signed [31:0] radial_k1;
    logic signed [31:0] radial_k2;
    logic signed [31:0] tangential_p1;
    logic signed [31:0] tangential_p2;
  } cfg_t;

  // classified point: offset magnitudes and quotient signs
  typedef struct packed {
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic        neg_x;
    logic        neg_y;
  } item_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clip_t;

  // clip a wide signed value to signed 32 bit, flag when clipped
  function automatic clip_t clip32(input logic signed [63:0] v);
    clip_t r;
    if (v > S32_MAX) begin
      r.sat = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/ldpm_if.sv =====
// valid/ready channel interfaces of the lens distortion point map unit
// depends on nothing; input points and mapped results
interface ldpm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  modport source (output valid, in_x, in_y, input ready);
  modport sink   (input valid, in_x, in_y, output ready);
endinterface

interface ldpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               zero_focal;
  logic               saturated;
  modport source (output valid, out_x, out_y, zero_focal, saturated, input ready);
  modport sink   (input valid, out_x, out_y, zero_focal, saturated, output ready);
endinterface

// ===== sv/lens_distortion_point_map_unit.sv =====
// top level of the lens distortion point map unit: register file and channels
// depends on ldpm_pkg, ldpm_if, ldpm_front, ldpm_queue and ldpm_back

// Maps one undistorted Q.8 pixel point to its Brown-Conrady distorted position
// per transaction and takes a new point every clock while the output is drained.
// Most of the pipeline is the 34-stage radix-2 restoring divider that normalizes
// by the focal lengths; the rest holds the squares, a multiply and an add stage
// for each of the three Horner steps of the radial polynomial, the radial scaling,
// the distorted point sum and the focal product. A zero focal length gives zero
// outputs with zero_focal set. Registers must be written through cfg_we_i/
// cfg_index_i/cfg_data_i only while no point is in flight; not enforced here.
module lens_distortion_point_map_unit #(
  parameter logic signed [31:0] RADIAL_K3 = ldpm_pkg::RADIAL_K3_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ldpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ldpm_pkg::CoordW-1:0]   cfg_data_i,
  ldpm_in_if.sink                       in_i,
  ldpm_out_if.source                    out_o
);

  ldpm_pkg::cfg_t  cfg_q;
  ldpm_pkg::item_t f_item, q_item;
  logic            f_push, q_full, q_valid, b_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{principal_x: '0, principal_y: '0,
                 focal_x: ldpm_pkg::FOCAL_RESET, focal_y: ldpm_pkg::FOCAL_RESET,
                 radial_k1: '0, radial_k2: '0,
                 tangential_p1: '0, tangential_p2: '0};
    end else if (cfg_we_i) begin
      case (ldpm_pkg::reg_idx_e'(cfg_index_i))
        ldpm_pkg::REG_PRINCIPAL_X:   cfg_q.principal_x   <= cfg_data_i;
        ldpm_pkg::REG_PRINCIPAL_Y:   cfg_q.principal_y   <= cfg_data_i;
        ldpm_pkg::REG_FOCAL_X:       cfg_q.focal_x       <= cfg_data_i;
        ldpm_pkg::REG_FOCAL_Y:       cfg_q.focal_y       <= cfg_data_i;
        ldpm_pkg::REG_RADIAL_K1:     cfg_q.radial_k1     <= cfg_data_i;
        ldpm_pkg::REG_RADIAL_K2:     cfg_q.radial_k2     <= cfg_data_i;
        ldpm_pkg::REG_TANGENTIAL_P1: cfg_q.tangential_p1 <= cfg_data_i;
        ldpm_pkg::REG_TANGENTIAL_P2: cfg_q.tangential_p2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ldpm_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_i(in_i),
    .push_o(f_push), .item_o(f_item), .full_i(q_full)
  );

  ldpm_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_push), .data_i(f_item), .full_o(q_full),
    .pop_i(b_pop), .valid_o(q_valid), .data_o(q_item)
  );

  ldpm_back #(
    .RadialK3(RADIAL_K3)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(q_valid), .item_i(q_item),
    .pop_o(b_pop), .out_o(out_o)
  );

endmodule

// ===== sv/ldpm_front.sv =====
// front end: takes input transactions and classifies them for the divider
// depends on ldpm_pkg and ldpm_if
module ldpm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldpm_pkg::cfg_t    cfg_i,
  ldpm_in_if.sink           in_i,
  output logic              push_o,
  output ldpm_pkg::item_t   item_o,
  input  logic              full_i
);

  logic            fv_q, fv_d;
  ldpm_pkg::item_t item_q, item_d;
  logic            accept;
  logic signed [32:0] diff_x, diff_y;

  // holding register drains into the queue whenever it has room
  assign in_i.ready = !fv_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // offset from principal point, split into magnitude and quotient sign
  assign diff_x = 33'(in_i.in_x) - 33'(cfg_i.principal_x);
  assign diff_y = 33'(in_i.in_y) - 33'(cfg_i.principal_y);

  always_comb begin
    item_d.mag_x = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
    item_d.mag_y = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
    item_d.neg_x = diff_x[32] ^ cfg_i.focal_x[31];
    item_d.neg_y = diff_y[32] ^ cfg_i.focal_y[31];
  end

  always_comb begin
    fv_d = fv_q;
    if (accept) begin
      fv_d = 1'b1;
    end else if (!full_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign push_o = fv_q;
  assign item_o = item_q;

endmodule

// ===== sv/ldpm_queue.sv =====
// short queue between the front end and the arithmetic back end
// depends on ldpm_pkg
module ldpm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ldpm_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ldpm_pkg::item_t data_o
);

  localparam int unsigned Depth = ldpm_pkg::QDepth;
  localparam int unsigned AW    = ldpm_pkg::QAddrW;

  ldpm_pkg::item_t mem_q [Depth];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]     count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW+1)'(Depth))
    else $error("queue fill count out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + (AW+1)'(1))
    else $error("queue push lost");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> count_q == $past(count_q) - (AW+1)'(1))
    else $error("queue pop lost");

endmodule

// ===== sv/ldpm_div.sv =====
// pipelined restoring divider: trunc(mag * 2^30 / den), clipped to signed 32 bit
// depends on nothing outside; one quotient bit per stage, stalls on en_i
module ldpm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [32:0]        mag_i,
  input  logic               neg_i,
  input  logic signed [31:0] den_i,
  output logic               valid_o,
  output logic signed [31:0] quot_o,
  output logic               sat_o
);

  localparam int unsigned QW   = 32;
  localparam int unsigned NStg = QW + 1;

  logic [NStg-1:0] vld_q;
  logic [63:0]     rem_q [NStg];
  logic [QW-1:0]   q_q   [NStg];
  logic [NStg-1:0] neg_q;
  logic [NStg-1:0] big_q;
  logic [31:0]     dmag;
  logic [63:0]     num;
  logic            vout_q;
  logic signed [31:0] quot_q;
  logic            sat_q;
  logic [QW-1:0]   qf;
  logic            over;

  assign dmag = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign num  = {1'b0, mag_i, 30'b0};

  // first stage: load the numerator, flag a quotient too large for 32 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num;
      q_q[0]   <= '0;
      neg_q[0] <= neg_i;
      big_q[0] <= num >= {dmag, 32'b0};
    end
  end

  // one compare and subtract per quotient bit
  for (genvar k = 1; k < NStg; k++) begin : g_stage
    logic [63:0] trial;
    logic        ge;
    assign trial = 64'(dmag) << (QW - k);
    assign ge    = rem_q[k-1] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_q[k-1] - trial : rem_q[k-1];
        q_q[k]   <= q_q[k-1] | (ge ? (QW'(1) << (QW - k)) : '0);
        neg_q[k] <= neg_q[k-1];
        big_q[k] <= big_q[k-1];
      end
    end
  end

  // sign and saturation of the final quotient
  assign qf = q_q[NStg-1];
  always_comb begin
    if (neg_q[NStg-1]) begin
      over = big_q[NStg-1] || (qf[QW-1] && (qf[QW-2:0] != '0));
    end else begin
      over = big_q[NStg-1] || qf[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= over;
      if (neg_q[NStg-1]) begin
        quot_q <= over ? 32'sh80000000 : (~qf + 32'd1);
      end else begin
        quot_q <= over ? 32'sh7fffffff : qf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= {vld_q[NStg-2:0], valid_i};
      vout_q <= vld_q[NStg-1];
    end
  end

  assign valid_o = vout_q;
  assign quot_o  = quot_q;
  assign sat_o   = sat_q;

endmodule

// ===== sv/ldpm_back.sv =====
// back end: normalization divide, radial polynomial, tangential terms, pixel map
// depends on ldpm_pkg, ldpm_if and ldpm_div
module ldpm_back #(
  parameter logic signed [31:0] RadialK3 = ldpm_pkg::RADIAL_K3_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ldpm_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  ldpm_pkg::item_t item_i,
  output logic            pop_o,
  ldpm_out_if.source      out_o
);

  logic en;
  logic ovld_q;
  logic dvx, dvy;
  logic signed [31:0] dqx, dqy;
  logic dsx, dsy;
  logic [9:0] vld_q;

  // whole pipe advances whenever the output register is free or drained
  assign en    = !ovld_q || out_o.ready;
  assign pop_o = en;

  ldpm_div u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i), .mag_i(item_i.mag_x),
    .neg_i(item_i.neg_x), .den_i(cfg_i.focal_x),
    .valid_o(dvx), .quot_o(dqx), .sat_o(dsx)
  );

  ldpm_div u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i), .mag_i(item_i.mag_y),
    .neg_i(item_i.neg_y), .den_i(cfg_i.focal_y),
    .valid_o(dvy), .quot_o(dqy), .sat_o(dsy)
  );

  // stage registers
  logic signed [31:0] dx_a, dy_a, dx_b, dy_b, dx_c, dy_c, dx_d, dy_d;
  logic signed [31:0] dx_e, dy_e, dx_f, dy_f, dx_g, dy_g;
  logic sat_a, sat_b, sat_c, sat_d, sat_e, sat_f, sat_g, sat_h, sat_i, sat_j;
  logic signed [63:0] pxx_a, pyy_a, pxy_a;
  logic signed [28:0] r2_b, r2_c, r2_d, r2_e;
  logic signed [60:0] m0_b, m1_d, m2_f;
  logic signed [59:0] tpa_b, tqa_b;
  logic signed [61:0] tpb_b, tqb_b;
  logic signed [31:0] t1_c, t2_e, f_g;
  logic signed [45:0] tanx_c, tany_c, tanx_d, tany_d, tanx_e, tany_e;
  logic signed [45:0] tanx_f, tany_f, tanx_g, tany_g, tanx_h, tany_h;
  logic signed [63:0] ax_h, ay_h;
  logic signed [46:0] xd_i, yd_i;
  logic signed [62:0] phx_j, phy_j;
  logic signed [48:0] plx_j, ply_j;
  logic signed [31:0] ox_q, oy_q;
  logic               zf_q, sat_q;

  // combinational helpers
  logic signed [27:0] dx2, dy2, dxdy;
  logic signed [28:0] r2;
  logic signed [29:0] argx, argy;
  logic signed [63:0] tsx, tsy;
  ldpm_pkg::clip_t    c1, c2, cf, cx, cy;
  logic signed [79:0] fullx, fully;
  logic               zero;

  assign dx2  = pxx_a[63:36];
  assign dy2  = pyy_a[63:36];
  assign dxdy = pxy_a[63:36];
  assign r2   = 29'(dx2) + 29'(dy2);
  assign argx = 30'(r2) + (30'(dx2) <<< 1);
  assign argy = 30'(r2) + (30'(dy2) <<< 1);

  assign tsx = (64'(tpa_b) <<< 1) + 64'(tpb_b);
  assign tsy = (64'(tqa_b) <<< 1) + 64'(tqb_b);

  // radial polynomial in Horner form, one multiply then one add per step
  assign c1 = ldpm_pkg::clip32(64'(cfg_i.radial_k2) + 64'(m0_b >>> 24));
  assign c2 = ldpm_pkg::clip32(64'(cfg_i.radial_k1) + 64'(m1_d >>> 24));
  assign cf = ldpm_pkg::clip32(ldpm_pkg::Q24_ONE + 64'(m2_f >>> 24));

  // back to pixels
  assign fullx = (80'(phx_j) <<< 16) + 80'(plx_j);
  assign fully = (80'(phy_j) <<< 16) + 80'(ply_j);
  assign cx = ldpm_pkg::clip32(64'(fullx >>> 30) + 64'(cfg_i.principal_x));
  assign cy = ldpm_pkg::clip32(64'(fully >>> 30) + 64'(cfg_i.principal_y));
  assign zero = (cfg_i.focal_x == '0) || (cfg_i.focal_y == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // squares and cross term
      dx_a  <= dqx;
      dy_a  <= dqy;
      sat_a <= dsx | dsy;
      pxx_a <= 64'(dqx) * 64'(dqx);
      pyy_a <= 64'(dqy) * 64'(dqy);
      pxy_a <= 64'(dqx) * 64'(dqy);
      // r squared, first radial product, tangential products
      dx_b  <= dx_a;
      dy_b  <= dy_a;
      sat_b <= sat_a;
      r2_b  <= r2;
      m0_b  <= 61'(r2) * 61'(RadialK3);
      tpa_b <= 60'(cfg_i.tangential_p1) * 60'(dxdy);
      tpb_b <= 62'(cfg_i.tangential_p2) * 62'(argx);
      tqa_b <= 60'(cfg_i.tangential_p2) * 60'(dxdy);
      tqb_b <= 62'(cfg_i.tangential_p1) * 62'(argy);
      // k2 step, tangential sums
      dx_c   <= dx_b;
      dy_c   <= dy_b;
      r2_c   <= r2_b;
      t1_c   <= c1.val;
      sat_c  <= sat_b | c1.sat;
      tanx_c <= tsx[63:18];
      tany_c <= tsy[63:18];
      // second radial product
      dx_d   <= dx_c;
      dy_d   <= dy_c;
      r2_d   <= r2_c;
      sat_d  <= sat_c;
      tanx_d <= tanx_c;
      tany_d <= tany_c;
      m1_d   <= 61'(r2_c) * 61'(t1_c);
      // k1 step
      dx_e   <= dx_d;
      dy_e   <= dy_d;
      r2_e   <= r2_d;
      t2_e   <= c2.val;
      sat_e  <= sat_d | c2.sat;
      tanx_e <= tanx_d;
      tany_e <= tany_d;
      // third radial product
      dx_f   <= dx_e;
      dy_f   <= dy_e;
      sat_f  <= sat_e;
      tanx_f <= tanx_e;
      tany_f <= tany_e;
      m2_f   <= 61'(r2_e) * 61'(t2_e);
      // radial factor
      dx_g   <= dx_f;
      dy_g   <= dy_f;
      f_g    <= cf.val;
      sat_g  <= sat_f | cf.sat;
      tanx_g <= tanx_f;
      tany_g <= tany_f;
      // radial scaling of the normalized point
      ax_h   <= 64'(dx_g) * 64'(f_g);
      ay_h   <= 64'(dy_g) * 64'(f_g);
      sat_h  <= sat_g;
      tanx_h <= tanx_g;
      tany_h <= tany_g;
      // distorted normalized point
      xd_i  <= 47'(64'(ax_h >>> 24) + 64'(tanx_h));
      yd_i  <= 47'(64'(ay_h >>> 24) + 64'(tany_h));
      sat_i <= sat_h;
      // focal length product split in two partial products
      phx_j <= 63'(cfg_i.focal_x) * 63'(xd_i >>> 16);
      phy_j <= 63'(cfg_i.focal_y) * 63'(yd_i >>> 16);
      plx_j <= 49'(cfg_i.focal_x) * 49'($signed({1'b0, xd_i[15:0]}));
      ply_j <= 49'(cfg_i.focal_y) * 49'($signed({1'b0, yd_i[15:0]}));
      sat_j <= sat_i;
      // output register
      zf_q  <= zero;
      ox_q  <= zero ? '0 : cx.val;
      oy_q  <= zero ? '0 : cy.val;
      sat_q <= zero ? 1'b0 : (sat_j | cx.sat | cy.sat);
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else if (en) begin
      vld_q  <= {vld_q[8:0], dvx & dvy};
      ovld_q <= vld_q[9];
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.out_x      = ox_q;
  assign out_o.out_y      = oy_q;
  assign out_o.zero_focal = zf_q;
  assign out_o.saturated  = sat_q;

endmodule
